>>> src/ssmmm_pkg.sv
// Package for the set statistics block: shared types and constants.
// No dependencies; used by ssmmm_fifo, ssmmm_core and the top level.
package ssmmm_pkg;
    localparam int RESULT_CAP = 32;

    typedef struct packed {
        logic [15:0] sample;
        logic        final_item;
    } t_item;
endpackage

>>> src/ssmmm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ssmmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> src/ssmmm_fifo.sv
// Two-entry queue between the accepting front and the computing back part.
// Depends on ssmmm_pkg.
module ssmmm_fifo import ssmmm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_stall,
    output t_item o_item
);
    t_item      r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

>>> src/ssmmm_core.sv
// Back part: stores samples, sorts by selection sort, computes mean, median,
// modes and emits one result per mode, at most RESULT_CAP. Depends on ssmmm_pkg and ssmmm_ram.
module ssmmm_core import ssmmm_pkg::*; #(
    parameter int MAX_VALUES = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_set_size,
    output logic [23:0] o_mean_q8,
    output logic [15:0] o_median_value,
    output logic [15:0] o_mode_value,
    output logic [5:0]  o_mode_total,
    output logic        o_dropped_flag,
    output logic        o_last_result
);
    localparam int AW = $clog2(MAX_VALUES);
    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam int SW = VALUE_BITS + CW;
    localparam int DW = SW + 8;

    localparam logic [3:0] S_LOAD = 4'd0, S_SA = 4'd1, S_SB = 4'd2, S_SC = 4'd3,
                           S_SW1 = 4'd4, S_SW2 = 4'd5, S_DIV = 4'd6, S_MED1 = 4'd7,
                           S_MED2 = 4'd8, S_SCAN = 4'd9, S_SCANW = 4'd10,
                           S_EMIT = 4'd11, S_EOUT = 4'd12, S_MRD = 4'd13;

    logic [3:0]            r_st;
    logic [CW-1:0]         r_n, r_a, r_b, r_m, r_modes, r_i;
    logic                  r_ovf;
    logic [VALUE_BITS-1:0] r_minv, r_va, r_cur, r_lo;
    logic [CW-1:0]         r_run, r_best;
    logic [SW-1:0]         r_sum;
    logic [DW-1:0]         r_rem, r_quo;
    logic [5:0]            r_dcnt;
    logic [VALUE_BITS:0]   r_med;

    logic                  w_we, w_mwe;
    logic [AW-1:0]         w_waddr, w_raddr, w_mwaddr, w_mraddr;
    logic [VALUE_BITS-1:0] w_wdata, w_rdata, w_mwdata, w_mrdata;
    logic [DW-1:0]         w_trial;
    logic [CW-1:0]         w_run;

    ssmmm_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_VALUES)) u_vals (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata));
    ssmmm_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_VALUES)) u_modes (
        .i_clk(i_clk), .i_we(w_mwe), .i_waddr(w_mwaddr), .i_wdata(w_mwdata),
        .i_raddr(w_mraddr), .o_rdata(w_mrdata));

    assign o_stall = (r_st != S_LOAD);
    assign w_run   = (r_i != '0 && w_rdata == r_cur) ? r_run + 1'b1 : CW'(1);
    assign w_trial = {r_rem[DW-2:0], r_quo[DW-1]} - DW'(r_n);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_n[AW-1:0];
        w_wdata = VALUE_BITS'(i_item.sample);
        w_raddr = r_b[AW-1:0];
        if (r_st == S_LOAD) begin
            w_we = i_valid && (r_n != CW'(MAX_VALUES));
        end else if (r_st == S_SW1) begin
            w_we = 1'b1; w_waddr = r_m[AW-1:0]; w_wdata = r_va;
        end else if (r_st == S_SW2) begin
            w_we = 1'b1; w_waddr = r_a[AW-1:0]; w_wdata = r_minv;
        end
        w_mwe    = (r_st == S_SCANW) && (w_run >= r_best);
        w_mwaddr = (w_run > r_best) ? '0 : r_modes[AW-1:0];
        w_mwdata = w_rdata;
        w_mraddr = r_i[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD; r_n <= '0; r_ovf <= 1'b0; o_valid <= 1'b0;
        end else begin
            case (r_st)
                S_LOAD: if (i_valid) begin
                    if (r_n != CW'(MAX_VALUES)) r_n <= r_n + 1'b1;
                    else r_ovf <= 1'b1;
                    if (i_item.final_item) begin
                        r_st <= S_SA; r_a <= '0; r_b <= '0; r_sum <= '0;
                    end
                end
                S_SA: begin
                    // Read issued for position a; it becomes the first minimum.
                    if (r_a == r_n) begin
                        r_st <= S_DIV; r_rem <= '0;
                        r_quo <= {r_sum, 8'd0}; r_dcnt <= 6'(DW);
                    end else begin
                        r_st <= S_SB; r_b <= r_a + 1'b1;
                    end
                end
                S_SB: begin
                    r_va <= w_rdata; r_minv <= w_rdata; r_m <= r_a;
                    r_st <= S_SC; r_b <= r_b + 1'b1;
                end
                S_SC: begin
                    // w_rdata holds the element at b-1.
                    if (r_b - 1'b1 < r_n) begin
                        if (w_rdata < r_minv) begin
                            r_minv <= w_rdata; r_m <= r_b - 1'b1;
                        end
                        r_b <= r_b + 1'b1;
                    end else begin
                        r_st <= S_SW1;
                    end
                end
                S_SW1: r_st <= S_SW2;
                S_SW2: begin
                    r_sum <= r_sum + SW'(r_minv);
                    r_a <= r_a + 1'b1; r_b <= r_a + 1'b1; r_st <= S_SA;
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    if (r_dcnt == '0) begin
                        r_st <= S_MED1; r_b <= {1'b0, r_n[CW-1:1]} - CW'(r_n[0] ? 0 : 1);
                    end else begin
                        r_dcnt <= r_dcnt - 1'b1;
                        if (!w_trial[DW-1] || r_rem[DW-1]) begin
                            r_rem <= w_trial; r_quo <= {r_quo[DW-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[DW-2:0], r_quo[DW-1]};
                            r_quo <= {r_quo[DW-2:0], 1'b0};
                        end
                    end
                end
                S_MED1: begin
                    r_b <= {1'b0, r_n[CW-1:1]}; r_st <= S_MED2;
                end
                S_MED2: begin
                    r_lo <= w_rdata; r_st <= S_SCAN; r_b <= '0;
                end
                S_SCAN: begin
                    if (r_n[0]) r_med <= {1'b0, w_rdata};
                    else r_med <= ({1'b0, w_rdata} + {1'b0, r_lo}) >> 1;
                    r_i <= '0; r_run <= '0; r_best <= CW'(1); r_modes <= '0;
                    r_b <= '0; r_st <= S_SCANW;
                end
                S_SCANW: begin
                    // Data for index b-1 arrives in the cycle after its address.
                    if (r_b == '0) begin
                        r_b <= r_b + 1'b1;
                    end else begin
                        r_cur <= w_rdata; r_run <= w_run;
                        if (w_run > r_best) begin
                            r_best <= w_run; r_modes <= CW'(1);
                        end else if (w_run == r_best) begin
                            r_modes <= r_modes + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                        if (r_i + 1'b1 == r_n) r_st <= S_EMIT;
                        else r_b <= r_b + 1'b1;
                    end
                end
                S_EMIT: begin
                    r_i <= '0; r_st <= S_MRD;
                end
                S_MRD: r_st <= S_EOUT;
                S_EOUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid <= 1'b1;
                        o_set_size <= 6'(r_n);
                        o_mean_q8 <= 24'(r_quo);
                        o_median_value <= 16'(r_med[VALUE_BITS-1:0]);
                        o_mode_value <= 16'(w_mrdata);
                        o_mode_total <= 6'(r_modes);
                        o_dropped_flag <= r_ovf;
                        o_last_result <= (r_i + 1'b1 == r_modes) ||
                                         (r_i + 1'b1 == CW'(RESULT_CAP));
                        if ((r_i + 1'b1 == r_modes) || (r_i + 1'b1 == CW'(RESULT_CAP))) begin
                            r_st <= S_LOAD; r_n <= '0; r_ovf <= 1'b0;
                        end else begin
                            r_i <= r_i + 1'b1; r_st <= S_MRD;
                        end
                    end
                end
                default: r_st <= S_LOAD;
            endcase
            if (o_valid && !i_stall && !(r_st == S_EOUT)) o_valid <= 1'b0;
        end
    end
endmodule

>>> src/sorted_set_mean_median_mode_top.sv
// Top level of the set statistics block: front queue and computing core.
// Depends on ssmmm_pkg, ssmmm_fifo and ssmmm_core.
//
// Usage: samples enter on i_sample with i_valid; i_final_item marks the
// last sample of a set. An item is accepted when i_valid is high and
// o_stall is low. Samples beyond MAX_VALUES are dropped and flagged.
// After the final item the core sorts the set by selection sort (each
// pass finds the minimum of the unsorted rest and swaps it into place),
// divides for the mean one quotient bit per cycle, scans for modes
// and then sends one result per mode, ascending, at most RESULT_CAP.
// Loading never stalls the queue, so throughput is set by the sort
// loop on the value memory, which has one write and one read port.
// A two-entry queue in front accepts until full while the core is busy.
// Results appear on o_valid; while i_stall is high the result holds.
// Reset (synchronous, active low) empties the queue and the set.
module sorted_set_mean_median_mode_top import ssmmm_pkg::*; #(
    parameter int MAX_VALUES = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_sample,
    input  logic        i_final_item,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_set_size,
    output logic [23:0] o_mean_q8,
    output logic [15:0] o_median_value,
    output logic [15:0] o_mode_value,
    output logic [5:0]  o_mode_total,
    output logic        o_dropped_flag,
    output logic        o_last_result
);
    t_item w_in, w_q;
    logic  w_qv, w_qs;

    assign w_in.sample     = i_sample;
    assign w_in.final_item = i_final_item;

    ssmmm_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(w_in), .o_valid(w_qv), .i_stall(w_qs), .o_item(w_q));

    ssmmm_core #(.MAX_VALUES(MAX_VALUES), .VALUE_BITS(VALUE_BITS)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_stall(w_qs),
        .i_item(w_q), .o_valid(o_valid), .i_stall(i_stall),
        .o_set_size(o_set_size), .o_mean_q8(o_mean_q8),
        .o_median_value(o_median_value), .o_mode_value(o_mode_value),
        .o_mode_total(o_mode_total), .o_dropped_flag(o_dropped_flag),
        .o_last_result(o_last_result));
endmodule
